// ----- hdl/vac_pkg.sv -----
// Package for the vibration alert controller: types, codes and reset constants.
`timescale 1ns / 1ps
package vac_pkg;

    localparam int unsigned DUR_W  = 24;
    localparam int unsigned TMR_W  = 16;
    localparam int unsigned CNT_W  = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned TEST_TIMER_BITS_DEF = 24;

    localparam logic [TMR_W-1:0] WINDOW_RST    = 16'd800;
    localparam logic [CNT_W-1:0] THRESHOLD_RST = 4'd3;
    localparam logic [TMR_W-1:0] ATTEND_RST    = 16'd30000;
    localparam logic [TMR_W-1:0] LAMP_RST      = 16'd30000;
    localparam logic [CNT_W-1:0] EDGE_MAX      = 4'd15;

    localparam logic [2:0] RELAY_VIB1 = 3'b001;
    localparam logic [2:0] RELAY_VIB2 = 3'b010;
    localparam logic [2:0] RELAY_LAMP = 3'b100;
    localparam logic [2:0] RELAY_ALL  = 3'b111;
    localparam logic [2:0] RELAY_OFF  = 3'b000;

    typedef enum logic [2:0] {
        FN_TICK   = 3'd0,
        FN_SENSOR = 3'd1,
        FN_BUTTON = 3'd2,
        FN_ARM    = 3'd3,
        FN_TEST   = 3'd4,
        FN_FORCE  = 3'd5
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW    = 3'd0,
        CFG_THRESHOLD = 3'd1,
        CFG_ATTEND    = 3'd2,
        CFG_LAMP      = 3'd3,
        CFG_POLARITY  = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_ARMED   = 4'b0010,
        MODE_ALARM   = 4'b0100,
        MODE_CALLING = 4'b1000
    } t_mode;

    localparam logic [1:0] MODE_CODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_CODE_ARMED   = 2'd1;
    localparam logic [1:0] MODE_CODE_ALARM   = 2'd2;
    localparam logic [1:0] MODE_CODE_CALLING = 2'd3;

    typedef struct packed {
        logic [2:0]       func;
        logic             arm_present;
        logic             button_pressed;
        logic             force_vib1;
        logic             force_vib2;
        logic             force_lamp;
        logic [DUR_W-1:0] duration_ms;
    } t_in_word;

    typedef struct packed {
        logic [2:0]       relay_levels;
        logic [1:0]       mode;
        logic             call_request;
        logic             hangup;
        logic             test_running;
        logic [CNT_W-1:0] edge_count;
    } t_out_word;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        case (m)
            MODE_IDLE:    c = MODE_CODE_IDLE;
            MODE_ARMED:   c = MODE_CODE_ARMED;
            MODE_ALARM:   c = MODE_CODE_ALARM;
            MODE_CALLING: c = MODE_CODE_CALLING;
            default:      c = MODE_CODE_IDLE;
        endcase
        return c;
    endfunction

    function automatic logic [TMR_W-1:0] at_least_one(input logic [TMR_W-1:0] v);
        return (v == '0) ? TMR_W'(1) : v;
    endfunction

endpackage

// ----- hdl/vibration_alert_controller_unit.sv -----
// Vibration alert controller top level: event register, state update and result register.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+------------------------
//  in      | to block  | i_in_valid / o_in_stall    | i_in_word  (t_in_word)
//  out     | from block| o_out_valid / i_out_stall  | o_out_word (t_out_word)
//  cfg     | to block  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One event per cycle sustained unless the output stalls; the result word is registered.
// Throughput is set by the combinational state update between event and result registers.
// Synchronous active-low reset: idle mode, timers stopped, relays off, registers at defaults.
// A stalled result holds the event register; the input stalls only when both are full.
`timescale 1ns / 1ps
module vibration_alert_controller_unit #(
    parameter int unsigned TEST_TIMER_BITS = vac_pkg::TEST_TIMER_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  vac_pkg::t_in_word                   i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output vac_pkg::t_out_word                  o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vac_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vac_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import vac_pkg::*;

    localparam int unsigned WIDE_W = 33;
    localparam logic [TEST_TIMER_BITS-1:0] TEST_ONE = TEST_TIMER_BITS'(1);

    // configuration
    logic [TMR_W-1:0] r_window_len;
    logic [CNT_W-1:0] r_threshold;
    logic [TMR_W-1:0] r_attend_len;
    logic [TMR_W-1:0] r_lamp_len;
    logic             r_active_high;

    // event and result registers
    logic      r_in_vld;
    t_in_word  r_in;
    logic      r_out_vld;
    t_out_word r_out, n_out;

    // block state
    t_mode                     r_mode, n_mode;
    logic [CNT_W-1:0]          r_edges, n_edges;
    logic [TMR_W-1:0]          r_window_left, n_window_left;
    logic [TMR_W-1:0]          r_attend_left, n_attend_left;
    logic [TMR_W-1:0]          r_lamp_left, n_lamp_left;
    logic [TEST_TIMER_BITS-1:0] r_test_left, n_test_left;
    logic                      r_test_flag, n_test_flag;
    logic [2:0]                r_relay, n_relay;
    logic                      r_prev_arm, n_prev_arm;

    logic adv, proc, in_acc;
    logic [WIDE_W-1:0] dur_wide;
    logic [WIDE_W-1:0] test_max_wide;
    logic [TEST_TIMER_BITS-1:0] test_load;
    logic [CNT_W-1:0] edge_inc;
    logic call_req, hang;

    assign adv         = !r_out_vld || !i_out_stall;
    assign proc        = r_in_vld && adv;
    assign o_in_stall  = r_in_vld && !adv;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // duration saturates to the test timer width; zero loads as one
    assign dur_wide      = WIDE_W'(r_in.duration_ms);
    assign test_max_wide = WIDE_W'({TEST_TIMER_BITS{1'b1}});
    always_comb begin
        if (dur_wide > test_max_wide) begin
            test_load = {TEST_TIMER_BITS{1'b1}};
        end else if (dur_wide == '0) begin
            test_load = TEST_ONE;
        end else begin
            test_load = dur_wide[TEST_TIMER_BITS-1:0];
        end
    end

    assign edge_inc = (r_edges < EDGE_MAX) ? r_edges + CNT_W'(1) : EDGE_MAX;

    always_comb begin
        n_mode        = r_mode;
        n_edges       = r_edges;
        n_window_left = r_window_left;
        n_attend_left = r_attend_left;
        n_lamp_left   = r_lamp_left;
        n_test_left   = r_test_left;
        n_test_flag   = r_test_flag;
        n_relay       = r_relay;
        n_prev_arm    = r_prev_arm;
        call_req      = 1'b0;
        hang          = 1'b0;
        case (r_in.func)
            FN_TICK: begin
                if (r_window_left != '0) begin
                    n_window_left = r_window_left - TMR_W'(1);
                    if (n_window_left == '0) begin
                        n_edges = '0;
                    end
                end
                if (r_attend_left != '0) begin
                    n_attend_left = r_attend_left - TMR_W'(1);
                    if (n_attend_left == '0 && r_mode == MODE_ALARM) begin
                        n_mode   = MODE_CALLING;
                        call_req = 1'b1;
                        n_relay  = RELAY_LAMP;
                    end
                end
                if (r_lamp_left != '0) begin
                    n_lamp_left = r_lamp_left - TMR_W'(1);
                    if (n_lamp_left == '0) begin
                        n_relay = n_relay & ~RELAY_LAMP;
                    end
                end
                if (r_test_left != '0) begin
                    n_test_left = r_test_left - TEST_ONE;
                    if (n_test_left == '0) begin
                        n_test_flag = 1'b0;
                        n_relay     = RELAY_OFF;
                    end
                end
            end
            FN_SENSOR: begin
                if (!r_test_flag && r_mode == MODE_ARMED && r_in.arm_present) begin
                    if (edge_inc >= r_threshold) begin
                        n_edges       = '0;
                        n_window_left = '0;
                        n_mode        = MODE_ALARM;
                        n_relay       = RELAY_ALL;
                        n_attend_left = at_least_one(r_attend_len);
                    end else begin
                        n_edges       = edge_inc;
                        n_window_left = at_least_one(r_window_len);
                    end
                end
            end
            FN_BUTTON: begin
                if (r_test_flag) begin
                    n_relay     = RELAY_OFF;
                    n_test_left = '0;
                    n_test_flag = 1'b0;
                end
                if (r_in.button_pressed) begin
                    n_relay     = n_relay | RELAY_LAMP;
                    n_lamp_left = at_least_one(r_lamp_len);
                    if (r_mode == MODE_ALARM || r_mode == MODE_CALLING) begin
                        n_relay       = RELAY_LAMP;
                        n_attend_left = '0;
                        hang          = 1'b1;
                        n_mode        = r_in.arm_present ? MODE_ARMED : MODE_IDLE;
                    end
                end
            end
            FN_ARM: begin
                if (!r_test_flag && r_in.arm_present != r_prev_arm) begin
                    n_mode        = r_in.arm_present ? MODE_ARMED : MODE_IDLE;
                    n_attend_left = '0;
                    n_relay       = RELAY_OFF;
                    n_prev_arm    = r_in.arm_present;
                end
            end
            FN_TEST: begin
                n_test_flag = 1'b1;
                n_relay     = RELAY_ALL;
                n_test_left = test_load;
            end
            FN_FORCE: begin
                n_test_flag = 1'b1;
                n_relay     = (r_in.force_vib1 ? RELAY_VIB1 : RELAY_OFF)
                            | (r_in.force_vib2 ? RELAY_VIB2 : RELAY_OFF)
                            | (r_in.force_lamp ? RELAY_LAMP : RELAY_OFF);
                n_test_left = test_load;
            end
            default: begin
            end
        endcase

        n_out.relay_levels = r_active_high ? n_relay : ~n_relay;
        n_out.mode         = mode_code(n_mode);
        n_out.call_request = call_req;
        n_out.hangup       = hang;
        n_out.test_running = n_test_flag;
        n_out.edge_count   = n_edges;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len  <= WINDOW_RST;
            r_threshold   <= THRESHOLD_RST;
            r_attend_len  <= ATTEND_RST;
            r_lamp_len    <= LAMP_RST;
            r_active_high <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WINDOW:    r_window_len  <= i_cfg_data;
                CFG_THRESHOLD: r_threshold   <= i_cfg_data[CNT_W-1:0];
                CFG_ATTEND:    r_attend_len  <= i_cfg_data;
                CFG_LAMP:      r_lamp_len    <= i_cfg_data;
                CFG_POLARITY:  r_active_high <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_mode        <= MODE_IDLE;
            r_edges       <= '0;
            r_window_left <= '0;
            r_attend_left <= '0;
            r_lamp_left   <= '0;
            r_test_left   <= '0;
            r_test_flag   <= 1'b0;
            r_relay       <= RELAY_OFF;
            r_prev_arm    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (proc) begin
                r_in_vld <= 1'b0;
            end
            if (proc) begin
                r_out_vld     <= 1'b1;
                r_mode        <= n_mode;
                r_edges       <= n_edges;
                r_window_left <= n_window_left;
                r_attend_left <= n_attend_left;
                r_lamp_left   <= n_lamp_left;
                r_test_left   <= n_test_left;
                r_test_flag   <= n_test_flag;
                r_relay       <= n_relay;
                r_prev_arm    <= n_prev_arm;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_word;
        end
        if (proc) begin
            r_out <= n_out;
        end
    end

    a_call_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.call_request) |-> (r_out.mode == MODE_CODE_CALLING))
        else $error("call request without calling mode");

    a_hang_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.hangup) |->
        (r_out.mode == MODE_CODE_IDLE || r_out.mode == MODE_CODE_ARMED))
        else $error("hangup left alarm active");

    a_pulse_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.call_request && r_out.hangup))
        else $error("call request and hangup together");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> !o_in_stall)
        else $error("input stalled with empty event register");

    a_test_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_test_left != '0) |-> r_test_flag)
        else $error("test timer running without test flag");

endmodule

// ----- test/vac_checker.sv -----
// Checker for the vibration alert controller: watches all channels, predicts and compares words.
`timescale 1ns / 1ps
module vac_checker
    import vac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_word              i_in_word,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_word             i_out_word,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_faults = 0,
    output int                    o_pending = 0
);

    logic [TMR_W-1:0] win_len, att_len, lamp_len;
    logic [CNT_W-1:0] edge_thr;
    logic             pol_high;

    logic [1:0]       cur_mode;
    logic [CNT_W-1:0] edges;
    logic [TMR_W-1:0] win_left, att_left, lamp_left;
    logic [DUR_W-1:0] hold_left;
    logic             test_on;
    logic [2:0]       relays;
    logic             last_arm;

    t_out_word        expected_words[$];
    t_out_word        predicted, oldest;
    int               faults = 0;

    task automatic log_fault(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        faults++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            log_fault($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic clear_state();
        win_len   = WINDOW_RST;
        edge_thr  = THRESHOLD_RST;
        att_len   = ATTEND_RST;
        lamp_len  = LAMP_RST;
        pol_high  = 1'b0;
        cur_mode  = MODE_CODE_IDLE;
        edges     = '0;
        win_left  = '0;
        att_left  = '0;
        lamp_left = '0;
        hold_left = '0;
        test_on   = 1'b0;
        relays    = RELAY_OFF;
        last_arm  = 1'b0;
    endtask

    // one event through the alert state machine
    task automatic apply_event(input t_in_word w, output t_out_word r);
        logic [CNT_W-1:0] cnt;
        logic             call_p;
        logic             hang_p;
        call_p = 1'b0;
        hang_p = 1'b0;
        case (w.func)
            FN_TICK: begin
                if (win_left != 0) begin
                    win_left--;
                    if (win_left == 0) edges = '0;
                end
                if (att_left != 0) begin
                    att_left--;
                    if (att_left == 0 && cur_mode == MODE_CODE_ALARM) begin
                        cur_mode = MODE_CODE_CALLING;
                        call_p   = 1'b1;
                        relays   = RELAY_LAMP;
                    end
                end
                if (lamp_left != 0) begin
                    lamp_left--;
                    if (lamp_left == 0) relays = relays & ~RELAY_LAMP;
                end
                if (hold_left != 0) begin
                    hold_left--;
                    if (hold_left == 0) begin
                        test_on = 1'b0;
                        relays  = RELAY_OFF;
                    end
                end
            end
            FN_SENSOR: begin
                if (!test_on && cur_mode == MODE_CODE_ARMED && w.arm_present) begin
                    cnt      = (edges < EDGE_MAX) ? edges + 1'b1 : EDGE_MAX;
                    win_left = (win_len == 0) ? TMR_W'(1) : win_len;
                    if (cnt >= edge_thr) begin
                        edges    = '0;
                        win_left = '0;
                        cur_mode = MODE_CODE_ALARM;
                        relays   = RELAY_ALL;
                        att_left = (att_len == 0) ? TMR_W'(1) : att_len;
                    end else begin
                        edges = cnt;
                    end
                end
            end
            FN_BUTTON: begin
                if (test_on) begin
                    relays    = RELAY_OFF;
                    hold_left = '0;
                    test_on   = 1'b0;
                end
                if (w.button_pressed) begin
                    relays    = relays | RELAY_LAMP;
                    lamp_left = (lamp_len == 0) ? TMR_W'(1) : lamp_len;
                    if (cur_mode == MODE_CODE_ALARM || cur_mode == MODE_CODE_CALLING) begin
                        relays   = RELAY_LAMP;
                        att_left = '0;
                        hang_p   = 1'b1;
                        cur_mode = w.arm_present ? MODE_CODE_ARMED : MODE_CODE_IDLE;
                    end
                end
            end
            FN_ARM: begin
                if (!test_on && w.arm_present != last_arm) begin
                    cur_mode = w.arm_present ? MODE_CODE_ARMED : MODE_CODE_IDLE;
                    att_left = '0;
                    relays   = RELAY_OFF;
                    last_arm = w.arm_present;
                end
            end
            FN_TEST, FN_FORCE: begin
                test_on = 1'b1;
                if (w.func == FN_TEST)
                    relays = RELAY_ALL;
                else
                    relays = {w.force_lamp, w.force_vib2, w.force_vib1};
                // timer is as wide as the field, so only zero needs fixing
                hold_left = (w.duration_ms == 0) ? DUR_W'(1) : w.duration_ms;
            end
            default: ;
        endcase
        r.relay_levels = pol_high ? relays : ~relays;
        r.mode         = cur_mode;
        r.call_request = call_p;
        r.hangup       = hang_p;
        r.test_running = test_on;
        r.edge_count   = edges;
    endtask

    initial clear_state();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WINDOW:    win_len  = i_cfg_data;
                    CFG_THRESHOLD: edge_thr = i_cfg_data[CNT_W-1:0];
                    CFG_ATTEND:    att_len  = i_cfg_data;
                    CFG_LAMP:      lamp_len = i_cfg_data;
                    CFG_POLARITY:  pol_high = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                apply_event(i_in_word, predicted);
                expected_words.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    log_fault("result word with nothing expected");
                end else begin
                    oldest = expected_words.pop_front();
                    check_field("relay_levels", 8'(i_out_word.relay_levels),
                                8'(oldest.relay_levels));
                    check_field("mode", 8'(i_out_word.mode), 8'(oldest.mode));
                    check_field("call_request", 8'(i_out_word.call_request),
                                8'(oldest.call_request));
                    check_field("hangup", 8'(i_out_word.hangup), 8'(oldest.hangup));
                    check_field("test_running", 8'(i_out_word.test_running),
                                8'(oldest.test_running));
                    check_field("edge_count", 8'(i_out_word.edge_count),
                                8'(oldest.edge_count));
                end
            end
        end
        o_pending <= expected_words.size();
        o_faults  <= faults;
    end

endmodule

// ----- test/tb.sv -----
// Testbench top for the vibration alert controller: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
    import vac_pkg::*;

    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;
    localparam logic [2:0] FRC_VIB1_LAMP = RELAY_VIB1 | RELAY_LAMP;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_word              in_word = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  in_stall;
    logic                  out_valid;
    t_out_word             out_word;
    logic                  cfg_ready;
    int                    faults;
    int                    pending;

    int                    send_idle = 36;
    int                    recv_idle = 83;
    logic                  hold_go = 1'b0;
    logic                  hold_done = 1'b0;
    int                    sent = 0;

    logic [CNT_W-1:0]      thr_now = THRESHOLD_RST;
    int                    att_now = int'(ATTEND_RST);
    int                    lamp_now = int'(LAMP_RST);

    vibration_alert_controller_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    vac_checker chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_faults    (faults),
        .o_pending   (pending)
    );

    always #5 clk = ~clk;

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random stall, plus one long hold-off so the block backs up
    initial begin
        forever begin
            @(posedge clk);
            if (hold_go && !hold_done) begin
                out_stall <= 1'b1;
                repeat (80) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < recv_idle);
            end
        end
    end

    function automatic t_in_word mk(input logic [2:0] f, input logic arm, input logic btn,
                                    input logic [2:0] frc, input logic [DUR_W-1:0] dur);
        t_in_word w;
        w.func           = f;
        w.arm_present    = arm;
        w.button_pressed = btn;
        w.force_vib1     = frc[0];
        w.force_vib2     = frc[1];
        w.force_lamp     = frc[2];
        w.duration_ms    = dur;
        return w;
    endfunction

    function automatic logic [DUR_W-1:0] pick_dur();
        if ($urandom_range(0, 7) == 0)
            return DUR_W'($urandom());
        return DUR_W'($urandom_range(0, 12));
    endfunction

    task automatic offer(input t_in_word w);
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic ev(input logic [2:0] f, input logic arm, input logic btn);
        offer(mk(f, arm, btn, 3'($urandom()), pick_dur()));
    endtask

    task automatic settle();
        int n;
        n = 0;
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
            n++;
        end while (pending != 0 && n < 20000);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] win, input logic [15:0] thr,
                              input logic [15:0] att, input logic [15:0] lamp,
                              input logic [15:0] pol);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_ATTEND, att);
        write_reg(CFG_LAMP, lamp);
        write_reg(CFG_POLARITY, pol);
        cfg_valid <= 1'b0;
        thr_now  = thr[CNT_W-1:0];
        att_now  = int'(att);
        lamp_now = int'(lamp);
    endtask

    task automatic set_random_config();
        set_config(16'($urandom_range(1, 12)), 16'($urandom_range(1, 4)),
                   16'($urandom_range(1, 25)), 16'($urandom_range(1, 12)),
                   16'($urandom_range(0, 1)));
    endtask

    task automatic run_directed();
        ev(FN_TICK, 1'b0, 1'b0);
        offer(mk(FN_SPARE6, 1'b1, 1'b1, RELAY_ALL, 24'hFFFFFF));
        offer(mk(FN_SPARE7, 1'b0, 1'b0, RELAY_OFF, 24'h000000));
        ev(FN_SENSOR, 1'b1, 1'b0);
        ev(FN_ARM, 1'b1, 1'b0);
        ev(FN_SENSOR, 1'b0, 1'b0);
        repeat (3) ev(FN_SENSOR, 1'b1, 1'b0);
        ev(FN_TICK, 1'b1, 1'b0);
        ev(FN_BUTTON, 1'b1, 1'b0);
        ev(FN_BUTTON, 1'b1, 1'b1);
        offer(mk(FN_TEST, 1'b1, 1'b0, RELAY_OFF, 24'd0));
        ev(FN_SENSOR, 1'b1, 1'b0);
        ev(FN_TICK, 1'b1, 1'b0);
        offer(mk(FN_FORCE, 1'b0, 1'b0, FRC_VIB1_LAMP, 24'd2));
        ev(FN_ARM, 1'b0, 1'b0);
        ev(FN_TICK, 1'b0, 1'b0);
        ev(FN_TICK, 1'b0, 1'b0);
        offer(mk(FN_TEST, 1'b0, 1'b1, RELAY_ALL, 24'hFFFFFF));
        ev(FN_BUTTON, 1'b0, 1'b0);
        ev(FN_ARM, 1'b0, 1'b0);
        ev(FN_BUTTON, 1'b0, 1'b1);
    endtask

    // arm, enough edges to trip, wait into calling or not, then mostly acknowledge
    task automatic alarm_round();
        int need;
        int cap;
        need = (thr_now == 0) ? 1 : thr_now;
        ev(FN_BUTTON, 1'($urandom()), 1'b0);
        ev(FN_ARM, 1'b0, 1'b0);
        ev(FN_ARM, 1'b1, 1'b0);
        repeat (need) begin
            repeat ($urandom_range(0, 3)) ev(FN_TICK, 1'($urandom()), 1'($urandom()));
            ev(FN_SENSOR, ($urandom_range(0, 19) != 0), 1'($urandom()));
        end
        cap = (att_now + 3 > 40) ? 40 : att_now + 3;
        repeat ($urandom_range(0, cap)) ev(FN_TICK, 1'($urandom()), 1'($urandom()));
        if ($urandom_range(0, 3) != 0)
            ev(FN_BUTTON, 1'($urandom()), 1'b1);
        cap = (lamp_now + 2 > 30) ? 30 : lamp_now + 2;
        repeat ($urandom_range(0, cap)) ev(FN_TICK, 1'($urandom()), 1'($urandom()));
    endtask

    task automatic test_round();
        offer(mk($urandom_range(0, 1) ? FN_TEST : FN_FORCE, 1'($urandom()), 1'($urandom()),
                 3'($urandom()), DUR_W'($urandom_range(0, 12))));
        repeat ($urandom_range(0, 14)) begin
            case ($urandom_range(0, 5))
                0: ev(FN_SENSOR, 1'b1, 1'($urandom()));
                1: ev(FN_ARM, 1'($urandom()), 1'($urandom()));
                default: ev(FN_TICK, 1'($urandom()), 1'($urandom()));
            endcase
        end
        if ($urandom_range(0, 2) == 0)
            ev(FN_BUTTON, 1'($urandom()), 1'($urandom()));
    endtask

    task automatic play_random(input int n);
        int target;
        int r;
        target = sent + n;
        while (sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                alarm_round();
            else if (r < 70)
                test_round();
            else
                offer(mk(3'($urandom()), 1'($urandom()), 1'($urandom()), 3'($urandom()),
                         pick_dur()));
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        settle();
        set_config(16'd5, 16'd2, 16'd6, 16'd4, 16'd1);
        play_random(450);
        settle();
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        play_random(120);
        settle();
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        play_random(100);
        settle();

        send_idle = 83;
        recv_idle = 36;
        set_random_config();
        play_random(400);
        settle();

        send_idle = 0;
        recv_idle = 0;
        set_random_config();
        hold_go = 1'b1;
        play_random(450);
        settle();
        repeat (10) @(posedge clk);

        if (faults == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
